### sv/hac_pkg.sv
// Shared types and constants for the hydroponic actuator controller.
// Used by the top level and by its port checker. No dependencies.
package hac_pkg;

   // request kinds
   localparam logic REQ_SENSOR = 1'b0;
   localparam logic REQ_MANUAL = 1'b1;

   // relay indices for manual commands
   localparam logic [1:0] RELAY_PH_UP  = 2'd0;
   localparam logic [1:0] RELAY_PUMP   = 2'd1;
   localparam logic [1:0] RELAY_FAN    = 2'd2;
   localparam logic [1:0] RELAY_LIGHTS = 2'd3;

   // configuration register indices
   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 32;
   localparam logic [CSR_INDEX_W-1:0] CSR_SAFE_WATER_LEVEL = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PUMP_START_LEVEL = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PUMP_STOP_LEVEL  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_FAN_ON_TEMP      = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_FAN_OFF_TEMP     = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_PH_LOW_LIMIT     = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_DOSE_PULSE_MS    = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_DOSE_LOCKOUT_MS  = 3'd7;

   // register reset values
   localparam logic [9:0]         SAFE_WATER_LEVEL_RST = 10'd200;
   localparam logic [9:0]         PUMP_START_LEVEL_RST = 10'd400;
   localparam logic [9:0]         PUMP_STOP_LEVEL_RST  = 10'd900;
   localparam logic signed [11:0] FAN_ON_TEMP_RST      = 12'sd350;
   localparam logic signed [11:0] FAN_OFF_TEMP_RST     = 12'sd330;
   localparam logic [10:0]        PH_LOW_LIMIT_RST     = 11'd550;
   localparam logic [31:0]        DOSE_PULSE_MS_RST    = 32'd2000;
   localparam logic [31:0]        DOSE_LOCKOUT_MS_RST  = 32'd300000;

   // one result item
   typedef struct packed {
      logic ph_dose_drive;
      logic pump_drive;
      logic fan_drive;
      logic lights_drive;
      logic dry_run_lockout;
   } result_type;

endpackage

### sv/hydroponic_actuator_controller_unit.sv
// Hydroponic actuator controller: lockout, pump/fan hysteresis, pH dosing
// timer, lighting window and manual holds. Depends on hac_pkg.
// A sensor tick's result is registered in the result register, or in the skid register when one waits.
// Throughput: one item per cycle; result + skid register keep input flowing
// while one result waits, input stalls only when both are full. No result for manual.
// Reset (synchronous, active high) clears state, loads register defaults, empties output.
module hydroponic_actuator_controller_unit
   import hac_pkg::*;
#(
   parameter int unsigned LIGHT_ON_HOUR  = 6,
   parameter int unsigned LIGHT_OFF_HOUR = 20
) (
   input  logic                   clock,
   input  logic                   reset,
   // request channel
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   req_type,
   input  logic [31:0]            req_now_ms,
   input  logic [9:0]             req_water_level,
   input  logic                   req_water_level_ok,
   input  logic signed [11:0]     req_temperature,
   input  logic [10:0]            req_ph_value,
   input  logic [4:0]             req_hour_of_day,
   input  logic [1:0]             req_relay_select,
   input  logic                   req_relay_enable,
   // response channel
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic                   rsp_ph_dose_drive,
   output logic                   rsp_pump_drive,
   output logic                   rsp_fan_drive,
   output logic                   rsp_lights_drive,
   output logic                   rsp_dry_run_lockout,
   // configuration
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam logic [5:0] ON_HOUR  = 6'(LIGHT_ON_HOUR);
   localparam logic [5:0] OFF_HOUR = 6'(LIGHT_OFF_HOUR);

   // configuration registers
   logic [9:0]         safe_level_ff;
   logic [9:0]         start_level_ff;
   logic [9:0]         stop_level_ff;
   logic signed [11:0] fan_on_temp_ff;
   logic signed [11:0] fan_off_temp_ff;
   logic [10:0]        ph_low_ff;
   logic [31:0]        pulse_ms_ff;
   logic [31:0]        lockout_ms_ff;

   // control state
   logic        pump_on_ff, pump_on_in;
   logic        fan_on_ff, fan_on_in;
   logic        lights_on_ff, lights_on_in;
   logic [3:0]  hold_ff, hold_in;
   logic        pulse_active_ff, pulse_active_in;
   logic [31:0] pulse_start_ff, pulse_start_in;
   logic [31:0] last_end_ff, last_end_in;

   // output registers
   logic       out_valid_ff, out_valid_in;
   result_type out_ff, out_in;
   logic       skid_valid_ff, skid_valid_in;
   result_type skid_ff, skid_in;

   logic       req_xfer;
   logic       out_take;
   logic       new_result;
   result_type result;

   assign req_stall = skid_valid_ff;
   assign req_xfer  = req_valid && !req_stall;
   assign out_take  = out_valid_ff && !rsp_stall;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         safe_level_ff   <= SAFE_WATER_LEVEL_RST;
         start_level_ff  <= PUMP_START_LEVEL_RST;
         stop_level_ff   <= PUMP_STOP_LEVEL_RST;
         fan_on_temp_ff  <= FAN_ON_TEMP_RST;
         fan_off_temp_ff <= FAN_OFF_TEMP_RST;
         ph_low_ff       <= PH_LOW_LIMIT_RST;
         pulse_ms_ff     <= DOSE_PULSE_MS_RST;
         lockout_ms_ff   <= DOSE_LOCKOUT_MS_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_SAFE_WATER_LEVEL: safe_level_ff   <= csr_wdata[9:0];
            CSR_PUMP_START_LEVEL: start_level_ff  <= csr_wdata[9:0];
            CSR_PUMP_STOP_LEVEL:  stop_level_ff   <= csr_wdata[9:0];
            CSR_FAN_ON_TEMP:      fan_on_temp_ff  <= csr_wdata[11:0];
            CSR_FAN_OFF_TEMP:     fan_off_temp_ff <= csr_wdata[11:0];
            CSR_PH_LOW_LIMIT:     ph_low_ff       <= csr_wdata[10:0];
            CSR_DOSE_PULSE_MS:    pulse_ms_ff     <= csr_wdata;
            CSR_DOSE_LOCKOUT_MS:  lockout_ms_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // control update for one transfer
   always_comb begin
      logic        lockout;
      logic        pump;
      logic        fan;
      logic        allowed;
      logic        start;
      logic        active;
      logic [31:0] start_ms;
      logic        pulse_end;

      pump_on_in      = pump_on_ff;
      fan_on_in       = fan_on_ff;
      lights_on_in    = lights_on_ff;
      hold_in         = hold_ff;
      pulse_active_in = pulse_active_ff;
      pulse_start_in  = pulse_start_ff;
      last_end_in     = last_end_ff;
      new_result      = 1'b0;

      lockout = (req_water_level < safe_level_ff) || !req_water_level_ok;

      // pump hysteresis, forced off under lockout
      pump = pump_on_ff;
      if (lockout) begin
         pump = 1'b0;
      end else if (!hold_ff[RELAY_PUMP]) begin
         if (!pump && req_water_level < start_level_ff) pump = 1'b1;
         if (pump && req_water_level > stop_level_ff) pump = 1'b0;
      end

      // fan hysteresis
      fan = fan_on_ff;
      if (!hold_ff[RELAY_FAN]) begin
         if (!fan && req_temperature > fan_on_temp_ff) fan = 1'b1;
         if (fan && req_temperature < fan_off_temp_ff) fan = 1'b0;
      end

      // dosing pulse timer; end checked against the start of this same tick
      allowed   = (req_now_ms - last_end_ff) > lockout_ms_ff;
      start     = !hold_ff[RELAY_PH_UP] && allowed && (req_ph_value < ph_low_ff)
                  && !pulse_active_ff;
      active    = pulse_active_ff || start;
      start_ms  = start ? req_now_ms : pulse_start_ff;
      pulse_end = active && ((req_now_ms - start_ms) >= pulse_ms_ff);

      result.ph_dose_drive   = (hold_ff[RELAY_PH_UP] || (active && !pulse_end)) && !lockout;
      result.pump_drive      = pump;
      result.fan_drive       = fan;
      result.lights_drive    = hold_ff[RELAY_LIGHTS] ? lights_on_ff
                               : (({1'b0, req_hour_of_day} >= ON_HOUR)
                                  && ({1'b0, req_hour_of_day} < OFF_HOUR));
      result.dry_run_lockout = lockout;

      if (req_xfer) begin
         if (req_type == REQ_MANUAL) begin
            hold_in[req_relay_select] = req_relay_enable;
            case (req_relay_select)
               RELAY_PUMP:   pump_on_in   = req_relay_enable;
               RELAY_FAN:    fan_on_in    = req_relay_enable;
               RELAY_LIGHTS: lights_on_in = req_relay_enable;
               default: ;
            endcase
         end else begin
            new_result      = 1'b1;
            pump_on_in      = pump;
            fan_on_in       = fan;
            lights_on_in    = result.lights_drive;
            pulse_active_in = active && !pulse_end;
            pulse_start_in  = start_ms;
            last_end_in     = pulse_end ? req_now_ms : last_end_ff;
         end
      end
   end

   // result register with skid stage
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (skid_valid_ff) begin
         if (out_take) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (new_result) begin
         if (!out_valid_ff || out_take) begin
            out_valid_in = 1'b1;
            out_in       = result;
         end else begin
            skid_valid_in = 1'b1;
            skid_in       = result;
         end
      end else if (out_take) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pump_on_ff      <= 1'b0;
         fan_on_ff       <= 1'b0;
         lights_on_ff    <= 1'b0;
         hold_ff         <= '0;
         pulse_active_ff <= 1'b0;
         pulse_start_ff  <= '0;
         last_end_ff     <= '0;
         out_valid_ff    <= 1'b0;
         skid_valid_ff   <= 1'b0;
      end else begin
         pump_on_ff      <= pump_on_in;
         fan_on_ff       <= fan_on_in;
         lights_on_ff    <= lights_on_in;
         hold_ff         <= hold_in;
         pulse_active_ff <= pulse_active_in;
         pulse_start_ff  <= pulse_start_in;
         last_end_ff     <= last_end_in;
         out_valid_ff    <= out_valid_in;
         skid_valid_ff   <= skid_valid_in;
      end
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_ph_dose_drive   = out_ff.ph_dose_drive;
   assign rsp_pump_drive      = out_ff.pump_drive;
   assign rsp_fan_drive       = out_ff.fan_drive;
   assign rsp_lights_drive    = out_ff.lights_drive;
   assign rsp_dry_run_lockout = out_ff.dry_run_lockout;

endmodule

### sv/hac_checker.sv
// Port-level checks for the hydroponic actuator controller, bound to the top.
// Depends on hac_pkg and hydroponic_actuator_controller_unit.
module hac_checker
   import hac_pkg::*;
(
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_stall,
   input logic req_type,
   input logic rsp_valid,
   input logic rsp_stall,
   input logic rsp_ph_dose_drive,
   input logic rsp_pump_drive,
   input logic rsp_fan_drive,
   input logic rsp_lights_drive,
   input logic rsp_dry_run_lockout
);

   result_type rsp;
   assign rsp = '{rsp_ph_dose_drive, rsp_pump_drive, rsp_fan_drive,
                  rsp_lights_drive, rsp_dry_run_lockout};

   // output is empty right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // input backpressure only when a result is already waiting
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("input stalled with empty output");

   // lockout forces pump and dosing relays off
   a_lockout_drives: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_dry_run_lockout) |-> !(rsp_pump_drive || rsp_ph_dose_drive))
      else $error("relay driven under dry-run lockout");

   // a manual command transfer into an empty output adds no result
   a_manual_silent: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_type == REQ_MANUAL && !rsp_valid) |=> !rsp_valid)
      else $error("manual command produced a result");

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp)))
      else $error("stalled result changed");

endmodule

bind hydroponic_actuator_controller_unit hac_checker u_hac_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_valid),
   .req_stall          (req_stall),
   .req_type           (req_type),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_ph_dose_drive  (rsp_ph_dose_drive),
   .rsp_pump_drive     (rsp_pump_drive),
   .rsp_fan_drive      (rsp_fan_drive),
   .rsp_lights_drive   (rsp_lights_drive),
   .rsp_dry_run_lockout(rsp_dry_run_lockout)
);
